[design/assert_macros.svh]
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in the same cycle as ante
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/cfal_pkg.sv]
package cfal_pkg;

    typedef struct packed {
        logic [10:0] frame_id;
        logic        remote;
        logic [3:0]  length_code;
        logic [7:0]  byte_0;
        logic [7:0]  byte_1;
        logic [7:0]  byte_2;
        logic [7:0]  byte_3;
        logic [7:0]  byte_4;
        logic [7:0]  byte_5;
        logic [7:0]  byte_6;
        logic [7:0]  byte_7;
        logic [15:0] stamp_value;
    } frame_t;

    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } line_char_t;

    typedef struct packed {
        logic       active;
        logic [4:0] pos;
    } seq_ctrl_t;

    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_DATA   = 8'h74;
    localparam logic [7:0] CHAR_REMOTE = 8'h72;
    localparam logic [3:0] MAX_BYTES   = 4'd8;
    localparam logic [4:0] HEADER_LEN  = 5'd5;
    localparam logic [4:0] STAMP_LEN   = 5'd4;

    function automatic logic [7:0] hex_char(logic [3:0] n);
        logic [7:0] c;
        if (n < 4'd10)
        begin
            c = 8'h30 + {4'd0, n};
        end
        else
        begin
            c = 8'h41 + {4'd0, n} - 8'd10;
        end
        return c;
    endfunction

endpackage

[design/cfal_fmt.sv]
module cfal_fmt (
    input  cfal_pkg::frame_t     frame,
    input  cfal_pkg::seq_ctrl_t  ctrl,
    input  logic                 ts_en,
    output cfal_pkg::line_char_t result
);
    import cfal_pkg::*;

    logic [3:0] len_sat;
    logic [3:0] nbytes;
    logic [4:0] data_end;
    logic [4:0] stamp_end;
    logic [4:0] data_off;
    logic [4:0] stamp_off;
    logic [7:0] data_byte;
    logic [3:0] stamp_nib;

    always_comb
    begin
        len_sat   = (frame.length_code > MAX_BYTES) ? MAX_BYTES : frame.length_code;
        nbytes    = frame.remote ? 4'd0 : len_sat;
        data_end  = HEADER_LEN + {nbytes, 1'b0};
        stamp_end = data_end + (ts_en ? STAMP_LEN : 5'd0);
        data_off  = ctrl.pos - HEADER_LEN;
        stamp_off = ctrl.pos - data_end;

        unique case (data_off[3:1])
            3'd0: data_byte = frame.byte_0;
            3'd1: data_byte = frame.byte_1;
            3'd2: data_byte = frame.byte_2;
            3'd3: data_byte = frame.byte_3;
            3'd4: data_byte = frame.byte_4;
            3'd5: data_byte = frame.byte_5;
            3'd6: data_byte = frame.byte_6;
            default: data_byte = frame.byte_7;
        endcase

        unique case (stamp_off[1:0])
            2'd0: stamp_nib = frame.stamp_value[15:12];
            2'd1: stamp_nib = frame.stamp_value[11:8];
            2'd2: stamp_nib = frame.stamp_value[7:4];
            default: stamp_nib = frame.stamp_value[3:0];
        endcase

        result.last = 1'b0;
        priority if (ctrl.pos == 5'd0)
        begin
            result.character = frame.remote ? CHAR_REMOTE : CHAR_DATA;
        end
        else if (ctrl.pos == 5'd1)
        begin
            result.character = hex_char({1'b0, frame.frame_id[10:8]});
        end
        else if (ctrl.pos == 5'd2)
        begin
            result.character = hex_char(frame.frame_id[7:4]);
        end
        else if (ctrl.pos == 5'd3)
        begin
            result.character = hex_char(frame.frame_id[3:0]);
        end
        else if (ctrl.pos == 5'd4)
        begin
            result.character = hex_char(len_sat);
        end
        else if (ctrl.pos < data_end)
        begin
            result.character = hex_char(data_off[0] ? data_byte[3:0] : data_byte[7:4]);
        end
        else if (ctrl.pos < stamp_end)
        begin
            result.character = hex_char(stamp_nib);
        end
        else
        begin
            result.character = CHAR_CR;
            result.last      = 1'b1;
        end
    end

endmodule

[design/cfal_seq.sv]
module cfal_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  cfal_pkg::frame_t    frame,
    input  logic                char_last,
    output logic                busy,
    output cfal_pkg::frame_t    frame_held,
    output cfal_pkg::seq_ctrl_t ctrl
);
    import cfal_pkg::*;

    logic      accept;
    frame_t    frame_reg;
    seq_ctrl_t ctrl_reg;
    seq_ctrl_t ctrl_next;

    assign busy       = ctrl_reg.active && !char_last;
    assign accept     = start && !busy;
    assign frame_held = frame_reg;
    assign ctrl       = ctrl_reg;

    always_comb
    begin
        ctrl_next = ctrl_reg;
        priority if (accept)
        begin
            ctrl_next.active = 1'b1;
            ctrl_next.pos    = 5'd0;
        end
        else if (ctrl_reg.active)
        begin
            // advance, drop the line after carriage return
            ctrl_next.active = !char_last;
            ctrl_next.pos    = ctrl_reg.pos + 5'd1;
        end
        else
        begin
            ctrl_next = ctrl_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            frame_reg <= frame;
        end
    end

endmodule

[design/can_frame_to_ascii_line_unit.sv]
// CAN frame to serial-line ASCII formatter.
// Request channel: frame is taken at a rising edge with start high and busy low.
// Result channel: one character per cycle on result, marked by strobe for
// exactly one cycle; result.last marks the closing carriage return.
// The receiver cannot stall; every strobed character must be taken as shown.
// Configuration: cfg_data[0] (timestamp enable) is written when cfg_valid and
// cfg_ready are high; cfg_ready is always high. Write only while idle.
// Timing: the taken request is registered in the sequencer, and each character
// is registered in the single character register before it is strobed; the line
// then runs one character per cycle. A line holds 6 to 26 characters (5 header
// characters, 2 per data byte, 4 timestamp characters when enabled, carriage
// return). busy drops while the carriage return is formed, so the next request
// is taken then and lines follow with no gap.
// Reset: the line is dropped, no strobe, timestamp enable cleared.
module can_frame_to_ascii_line_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  cfal_pkg::frame_t     frame,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [0:0]           cfg_data,
    output logic                 strobe,
    output cfal_pkg::line_char_t result
);
    import cfal_pkg::*;

    frame_t     frame_held;
    seq_ctrl_t  ctrl;
    line_char_t char_next;
    line_char_t result_reg;
    logic       strobe_reg;
    logic       ts_en_reg;

    assign cfg_ready = 1'b1;
    assign strobe    = strobe_reg;
    assign result    = result_reg;

    cfal_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .frame      (frame),
        .char_last  (char_next.last),
        .busy       (busy),
        .frame_held (frame_held),
        .ctrl       (ctrl)
    );

    cfal_fmt u_fmt (
        .frame  (frame_held),
        .ctrl   (ctrl),
        .ts_en  (ts_en_reg),
        .result (char_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
            ts_en_reg  <= 1'b0;
        end
        else
        begin
            strobe_reg <= ctrl.active;
            if (cfg_valid && cfg_ready)
            begin
                ts_en_reg <= cfg_data[0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= char_next;
    end

endmodule

[design/cfal_checker.sv]
`include "assert_macros.svh"

module cfal_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 strobe,
    input cfal_pkg::line_char_t result
);
    import cfal_pkg::*;

    `ASSERT_SAME(a_line_opens, clk, rst_n, start && !busy, ##2 (strobe && (result.character == CHAR_DATA || result.character == CHAR_REMOTE)), "line does not open with a type letter")
    `ASSERT_SAME(a_last_is_cr, clk, rst_n, strobe && result.last, result.character == CHAR_CR, "last character is not carriage return")
    `ASSERT_NEXT(a_busy_emits, clk, rst_n, busy, strobe && !result.last, "busy without a following mid-line character")
    `ASSERT_NEXT(a_line_continues, clk, rst_n, strobe && !result.last, strobe, "line broken before carriage return")

endmodule

bind can_frame_to_ascii_line_unit cfal_checker u_cfal_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .strobe (strobe),
    .result (result)
);

[tb/can_frame_to_ascii_line_unit_tb.sv]
module can_frame_to_ascii_line_unit_tb;
    import cfal_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int PHASE_FRAMES = 75;
    localparam int PHASES       = 6;

    class ascii_line_checker;
        line_char_t expected_chars[$];
        bit         stamp_enable;
        int         mismatch_count;

        function new();
            stamp_enable   = 1'b0;
            mismatch_count = 0;
        endfunction

        function logic [7:0] nibble_ascii(logic [3:0] n);
            logic [7:0] c;
            if (n < 4'd10)
            begin
                c = 8'h30 | {4'd0, n};
            end
            else
            begin
                c = 8'h37 + {4'd0, n};
            end
            return c;
        endfunction

        function void push_char(logic [7:0] c, logic l);
            line_char_t e;
            e.character = c;
            e.last      = l;
            expected_chars.push_back(e);
        endfunction

        function void note_frame(frame_t f);
            logic [7:0] payload [8];
            logic [3:0] count;
            payload[0] = f.byte_0;
            payload[1] = f.byte_1;
            payload[2] = f.byte_2;
            payload[3] = f.byte_3;
            payload[4] = f.byte_4;
            payload[5] = f.byte_5;
            payload[6] = f.byte_6;
            payload[7] = f.byte_7;
            count = (f.length_code > 4'd8) ? 4'd8 : f.length_code;
            push_char(f.remote ? CHAR_REMOTE : CHAR_DATA, 1'b0);
            push_char(nibble_ascii({1'b0, f.frame_id[10:8]}), 1'b0);
            push_char(nibble_ascii(f.frame_id[7:4]), 1'b0);
            push_char(nibble_ascii(f.frame_id[3:0]), 1'b0);
            push_char(nibble_ascii(count), 1'b0);
            if (!f.remote)
            begin
                for (int i = 0; i < int'(count); i++)
                begin
                    push_char(nibble_ascii(payload[i][7:4]), 1'b0);
                    push_char(nibble_ascii(payload[i][3:0]), 1'b0);
                end
            end
            if (stamp_enable)
            begin
                push_char(nibble_ascii(f.stamp_value[15:12]), 1'b0);
                push_char(nibble_ascii(f.stamp_value[11:8]), 1'b0);
                push_char(nibble_ascii(f.stamp_value[7:4]), 1'b0);
                push_char(nibble_ascii(f.stamp_value[3:0]), 1'b0);
            end
            push_char(CHAR_CR, 1'b1);
        endfunction

        function void check_char(line_char_t got);
            line_char_t want;
            if (expected_chars.size() == 0)
            begin
                $error("character: expected none, got %h (last %b)", got.character, got.last);
                mismatch_count++;
                return;
            end
            want = expected_chars.pop_front();
            if (got.character !== want.character)
            begin
                $error("character: expected %h, got %h", want.character, got.character);
                mismatch_count++;
            end
            if (got.last !== want.last)
            begin
                $error("last: expected %b, got %b", want.last, got.last);
                mismatch_count++;
            end
        endfunction

        function int pending();
            return expected_chars.size();
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    frame_t     frame;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [0:0] cfg_data;
    logic       strobe;
    line_char_t result;

    ascii_line_checker line_check;
    int                cycle_count;

    can_frame_to_ascii_line_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .frame     (frame),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .strobe    (strobe),
        .result    (result)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && strobe)
        begin
            line_check.check_char(result);
        end
    end

    function automatic frame_t make_frame(logic [10:0] id, logic rtr, logic [3:0] len,
                                          logic [63:0] bytes, logic [15:0] stamp);
        frame_t f;
        f.frame_id    = id;
        f.remote      = rtr;
        f.length_code = len;
        f.byte_0      = bytes[63:56];
        f.byte_1      = bytes[55:48];
        f.byte_2      = bytes[47:40];
        f.byte_3      = bytes[39:32];
        f.byte_4      = bytes[31:24];
        f.byte_5      = bytes[23:16];
        f.byte_6      = bytes[15:8];
        f.byte_7      = bytes[7:0];
        f.stamp_value = stamp;
        return f;
    endfunction

    function automatic frame_t random_frame();
        logic [3:0] len;
        if ($urandom_range(0, 4) == 0)
        begin
            len = 4'($urandom_range(9, 15));
        end
        else
        begin
            len = 4'($urandom_range(0, 8));
        end
        return make_frame(11'($urandom_range(0, 2047)), ($urandom_range(0, 3) == 0), len,
                          {$urandom, $urandom}, 16'($urandom));
    endfunction

    // call at a falling edge; returns at the falling edge after acceptance
    task automatic send_frame(input frame_t f);
        frame <= f;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        line_check.note_frame(f);
        @(negedge clk);
    endtask

    task automatic write_stamp_enable(input bit en);
        while (line_check.pending() != 0 || busy)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= en;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        line_check.stamp_enable = en;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_directed();
        send_frame(make_frame(11'h000, 1'b0, 4'd0, 64'h0, 16'h0000));
        send_frame(make_frame(11'h7FF, 1'b0, 4'd8, 64'h0123456789ABCDEF, 16'hFFFF));
        send_frame(make_frame(11'h7FF, 1'b1, 4'd8, 64'hFFFFFFFFFFFFFFFF, 16'h5A5A));
        send_frame(make_frame(11'h5A3, 1'b1, 4'd0, 64'h0, 16'hA5C3));
        send_frame(make_frame(11'h2B4, 1'b0, 4'd15, 64'hFFFFFFFFFFFFFFFF, 16'h1234));
        send_frame(make_frame(11'h100, 1'b0, 4'd9, 64'h0, 16'hFEDC));
        send_frame(make_frame(11'h0E1, 1'b1, 4'd12, 64'hDEADBEEFCAFEF00D, 16'h8000));
        send_frame(make_frame(11'h3C5, 1'b0, 4'd1, 64'hA5FFFFFFFFFFFFFF, 16'h0001));
        send_frame(make_frame(11'h6DA, 1'b0, 4'd4, 64'hFEDCBA9800000000, 16'hBEEF));
        send_frame(make_frame(11'h01F, 1'b0, 4'd7, 64'h1020304050607080, 16'h7FFF));
        start <= 1'b0;
    endtask

    task automatic send_random(input int n);
        int left;
        int burst;
        int gap;
        left = n;
        while (left > 0)
        begin
            burst = $urandom_range(1, 12);
            while (burst > 0 && left > 0)
            begin
                send_frame(random_frame());
                burst--;
                left--;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            if (gap != 0)
            begin
                start <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        start <= 1'b0;
    endtask

    initial
    begin
        line_check  = new();
        cycle_count = 0;
        rst_n       = 1'b0;
        start       = 1'b0;
        frame       = '0;
        cfg_valid   = 1'b0;
        cfg_data    = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_directed();
        write_stamp_enable(1'b1);
        send_directed();

        for (int p = 0; p < PHASES; p++)
        begin
            write_stamp_enable(p % 2 == 1);
            send_random(PHASE_FRAMES);
        end

        while (line_check.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (40) @(posedge clk);

        if (line_check.mismatch_count == 0 && line_check.pending() == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+design
design/cfal_pkg.sv
design/cfal_fmt.sv
design/cfal_seq.sv
design/can_frame_to_ascii_line_unit.sv
design/cfal_checker.sv
tb/can_frame_to_ascii_line_unit_tb.sv
